@@ rtl/assert_macros.svh @@
// Assertion macros shared by the MPLS label stack parser RTL.
// Needs only a clock and an active-low reset from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must never be seen while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ rtl/mlsp_pkg.sv @@
// Shared types, codes and helper functions for the MPLS label stack parser.
// No dependencies; imported by every module of the block.
package mlsp_pkg;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_CLASS = 2'd1;
  localparam logic [1:0] KIND_TRUNC = 2'd2;

  localparam logic [1:0] PTYPE_UNKNOWN = 2'd0;
  localparam logic [1:0] PTYPE_IPV4    = 2'd1;
  localparam logic [1:0] PTYPE_IPV6    = 2'd2;
  localparam logic [1:0] PTYPE_OSI     = 2'd3;

  localparam logic [1:0] PHASE_STACK = 2'd0;
  localparam logic [1:0] PHASE_WAIT  = 2'd1;
  localparam logic [1:0] PHASE_DONE  = 2'd2;

  localparam logic [19:0] LABEL_IPV4_NULL = 20'd0;
  localparam logic [19:0] LABEL_IPV6_NULL = 20'd2;
  localparam logic [19:0] LABEL_IMPL_NULL = 20'd3;

  localparam logic [7:0] IPV4_LO = 8'h45;
  localparam logic [7:0] IPV4_HI = 8'h4f;
  localparam logic [7:0] IPV6_LO = 8'h60;
  localparam logic [7:0] IPV6_HI = 8'h6f;
  localparam logic [7:0] OSI_LO  = 8'h81;
  localparam logic [7:0] OSI_HI  = 8'h83;

  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] label;
    logic [2:0]  tc;
    logic        bos;
    logic [7:0]  ttl;
    logic [1:0]  ptype;
    logic        nopay;
    logic        last;
  } result_t;

  // Results produced by one consumed byte; count is 0 when nothing is pushed.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  function automatic logic [1:0] classify_byte(input logic [7:0] b);
    logic [1:0] t;
    t = PTYPE_UNKNOWN;
    if (b >= IPV4_LO && b <= IPV4_HI) t = PTYPE_IPV4;
    else if (b >= IPV6_LO && b <= IPV6_HI) t = PTYPE_IPV6;
    else if (b >= OSI_LO && b <= OSI_HI) t = PTYPE_OSI;
    return t;
  endfunction

  function automatic result_t make_entry(input logic [31:0] e);
    result_t r;
    r       = '0;
    r.kind  = KIND_ENTRY;
    r.label = e[31:12];
    r.tc    = e[11:9];
    r.bos   = e[8];
    r.ttl   = e[7:0];
    return r;
  endfunction

  function automatic result_t make_class(input logic [1:0] ptype, input logic nopay);
    result_t r;
    r       = '0;
    r.kind  = KIND_CLASS;
    r.ptype = ptype;
    r.nopay = nopay;
    return r;
  endfunction

  function automatic result_t make_trunc();
    result_t r;
    r      = '0;
    r.kind = KIND_TRUNC;
    return r;
  endfunction

endpackage

@@ rtl/mlsp_parser.sv @@
// Input register, parse state and per-byte decode of the label stack parser.
// Depends on mlsp_pkg; feeds result pairs to mlsp_out_queue.
module mlsp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // end_of_packet
  input  logic [1:0]            q_free,
  output mlsp_pkg::result_pair_t pair
);
  import mlsp_pkg::*;

  logic        hold_v_r;
  logic [7:0]  hold_byte_r;
  logic        hold_eop_r;

  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic [1:0]  phase_r, phase_nxt;

  logic [31:0] entry;
  logic [1:0]  n_res;
  result_t     r0, r1;
  logic        consume;

  assign entry = {shift_r, hold_byte_r};

  always_comb begin
    n_res     = 2'd0;
    r0        = make_trunc();
    r1        = make_trunc();
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    phase_nxt = phase_r;
    unique case (phase_r)
      PHASE_STACK: begin
        if (pos_r != 2'd3) begin
          shift_nxt = {shift_r[15:0], hold_byte_r};
          pos_nxt   = pos_r + 2'd1;
          n_res     = hold_eop_r ? 2'd1 : 2'd0;
        end else begin
          pos_nxt   = 2'd0;
          shift_nxt = '0;
          r0        = make_entry(entry);
          n_res     = 2'd1;
          if (!entry[8]) begin
            if (hold_eop_r) n_res = 2'd2;
          end else if (entry[31:12] == LABEL_IPV4_NULL || entry[31:12] == LABEL_IMPL_NULL) begin
            r1        = make_class(PTYPE_IPV4, 1'b0);
            n_res     = 2'd2;
            phase_nxt = PHASE_DONE;
          end else if (entry[31:12] == LABEL_IPV6_NULL) begin
            r1        = make_class(PTYPE_IPV6, 1'b0);
            n_res     = 2'd2;
            phase_nxt = PHASE_DONE;
          end else if (hold_eop_r) begin
            r1    = make_class(PTYPE_UNKNOWN, 1'b1);
            n_res = 2'd2;
          end else begin
            phase_nxt = PHASE_WAIT;
          end
        end
      end
      PHASE_WAIT: begin
        r0        = make_class(classify_byte(hold_byte_r), 1'b0);
        n_res     = 2'd1;
        phase_nxt = PHASE_DONE;
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // A byte leaves the input register only when the queue has room for all its results.
  assign consume   = hold_v_r && (n_res <= q_free);
  assign in_tready = !hold_v_r || consume;

  assign pair.count  = consume ? n_res : 2'd0;
  assign pair.first  = r0;
  assign pair.second = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      pos_r    <= 2'd0;
      shift_r  <= '0;
      phase_r  <= PHASE_STACK;
    end else begin
      if (in_tready) hold_v_r <= in_tvalid;
      if (consume) begin
        if (hold_eop_r) begin
          pos_r   <= 2'd0;
          shift_r <= '0;
          phase_r <= PHASE_STACK;
        end else begin
          pos_r   <= pos_nxt;
          shift_r <= shift_nxt;
          phase_r <= phase_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      hold_byte_r <= in_tdata;
      hold_eop_r  <= in_tlast;
    end
  end

endmodule

@@ rtl/mlsp_out_queue.sv @@
// Two-entry result queue whose head register drives the result channel.
// Depends on mlsp_pkg; takes result pairs from mlsp_parser.
module mlsp_out_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mlsp_pkg::result_pair_t            pair,
  output logic [1:0]                        q_free,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata from bit 0: label_value[19:0], traffic_class[22:20], bottom_of_stack[23],
  // time_to_live[31:24], payload_type[33:32], no_payload[34], zero pad [39:35]
  output logic [mlsp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                        out_tuser,  // [1:0] result_kind
  output logic                              out_tlast   // last_of_run
);
  import mlsp_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  result_t    q_r [2];
  result_t    q_nxt [2];
  logic       pop;
  logic [1:0] keep;
  result_t    head;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign keep       = cnt_r - {1'b0, pop};
  assign q_free     = 2'd2 - keep;
  assign cnt_nxt    = keep + pair.count;

  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    case (keep)
      2'd0: begin
        q_nxt[0] = pair.first;
        q_nxt[1] = pair.second;
      end
      2'd1: q_nxt[1] = pair.first;
      default: q_nxt[1] = q_r[1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign head      = q_r[0];
  assign out_tdata = {5'd0, head.nopay, head.ptype, head.ttl, head.bos, head.tc, head.label};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

@@ rtl/mpls_label_stack_parser.sv @@
// MPLS label stack parser: splits a byte stream into label stack entries and
// classifies the payload. Depends on mlsp_pkg, mlsp_parser, mlsp_out_queue.
//
// Usage: packet bytes enter on in_tdata, one per transaction, starting at the
// top label stack entry; in_tlast marks the final byte of the packet. Every
// fourth byte of the stack yields an entry result (out_tuser = 0); after the
// bottom entry one payload classification follows (out_tuser = 1), and a
// packet that ends inside the stack yields a truncation result (out_tuser = 2).
// out_tlast marks the last result caused by one input byte.
// With the queue empty, a result is presented on the output once its byte has
// passed the input register and then the queue head register.
// Throughput: one byte per cycle while each byte gives at most one result and out_tready stays high.
// The result channel moves one result per cycle while out_tready is high, so a byte
// that gives two results leaves a spare one behind; the two-entry queue takes up the
// spare result until the next such byte arrives.
// Reset (rst_n low, synchronous) empties both stages and returns the parse
// state to the top of a label stack. If the receiver stalls, the queue
// holds its results and the input register fills, then in_tready drops.
module mpls_label_stack_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,   // end_of_packet
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata from bit 0: label_value[19:0], traffic_class[22:20], bottom_of_stack[23],
  // time_to_live[31:24], payload_type[33:32], no_payload[34], zero pad [39:35]
  output logic [mlsp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                        out_tuser,  // [1:0] result_kind
  output logic                              out_tlast   // last_of_run
);
  import mlsp_pkg::*;
  `include "assert_macros.svh"

  result_pair_t pair;
  logic [1:0]   q_free;

  mlsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_free    (q_free),
    .pair      (pair)
  );

  mlsp_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair       (pair),
    .q_free     (q_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `ASSERT_IMPLIES(a_entry_no_class, clk, rst_n, out_tvalid && out_tuser == KIND_ENTRY, out_tdata[34:32] == 3'd0, "entry result carries class fields")
  `ASSERT_IMPLIES(a_nonentry_zero, clk, rst_n, out_tvalid && out_tuser != KIND_ENTRY, out_tdata[31:0] == 32'd0, "non-entry result carries entry fields")
  `ASSERT_IMPLIES(a_trunc_last, clk, rst_n, out_tvalid && out_tuser == KIND_TRUNC, out_tlast, "truncation result not last of run")
  `ASSERT_NEVER(a_nopay_known, clk, rst_n, out_tvalid && out_tdata[34] && out_tdata[33:32] != PTYPE_UNKNOWN, "no_payload with known payload type")
  `ASSERT_NEVER(a_queue_overfill, clk, rst_n, pair.count > q_free, "result queue overfilled")

endmodule
